>>> rtl/kict_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed interval conflict table.
// Holds sizes, status and command codes, and the types shared by the cell and the top level.
package kict_pkg;

    localparam int CAPACITY   = 64;
    localparam int TIME_WIDTH = 32;
    localparam int STOP_W     = TIME_WIDTH + 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int KEY_W      = 7;
    localparam int VEL_W      = 7;
    localparam int FIELD_W    = 32;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] start;
        logic [STOP_W-1:0]     stop;
        logic [KEY_W-1:0]      key;
        logic [VEL_W-1:0]      velocity;
    } note_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] remaining;
        logic             hit;
    } token_t;

endpackage

>>> rtl/kict_cell.sv
`timescale 1ns / 1ps
// One table cell: stores one note entry and checks the passing scan token against it.
// Depends on kict_pkg.
module kict_cell
    import kict_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  note_t  note,
    input  logic   wr_en,
    input  token_t tok_in,
    output token_t tok_out
);

    logic [TIME_WIDTH-1:0] entry_start_reg;
    logic [STOP_W-1:0]     entry_stop_reg;
    logic [KEY_W-1:0]      entry_key_reg;
    logic [VEL_W-1:0]      entry_velocity_reg;
    token_t                tok_reg;
    token_t                tok_next;
    logic                  active;
    logic                  match;

    always_comb
    begin
        active = tok_in.valid && (tok_in.remaining != '0);
        match  = active && (entry_key_reg == note.key)
                 && ({1'b0, entry_start_reg} < note.stop)
                 && (entry_stop_reg > {1'b0, note.start});
        tok_next.valid     = tok_in.valid;
        tok_next.remaining = active ? tok_in.remaining - CNT_W'(1) : tok_in.remaining;
        tok_next.hit       = tok_in.hit | match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_start_reg    <= note.start;
            entry_stop_reg     <= note.stop;
            entry_key_reg      <= note.key;
            entry_velocity_reg <= note.velocity;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/keyed_interval_conflict_table_unit.sv
`timescale 1ns / 1ps
// Top level of the keyed interval conflict table: control, chain of table cells, result register.
// Depends on kict_pkg and kict_cell.
//
// Usage:
// The slave channel takes one command word at a time: tuser holds the command (insert or
// clear) and tdata holds the note. The master channel returns one word per command: tuser
// holds the status and tdata holds the number of stored entries after the command.
// An insert launches a scan token into a chain of CAPACITY cells, one cell per cycle; each
// cell passes the token on, and each cell that holds an entry checks it for a same-key
// overlap. When the token leaves the last cell the insert is decided and, if added, written
// into the cell at the fill position once the result register is free. A clear skips the
// cell chain. The next command is accepted once the result of the last one is registered,
// so the unit does not take a new command while an insert's token is in the cell chain.
// The result register holds a word while the receiver stalls and a new command can be
// accepted meanwhile; the next result waits until that word is taken.
// Reset empties the table at once and clears the channel valid flags; no sweep is needed.
module keyed_interval_conflict_table_unit
    import kict_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: note_start[31:0], note_length[63:32], note_key[70:64],
    // note_velocity[77:71], zero padding[79:78].
    input  logic [79:0] s_tdata,
    // Fields from bit 0: cmd.
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: entry_count[6:0], zero padding[7].
    output logic [7:0]  m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [1:0]  m_tuser
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t                state_reg;
    note_t                 note_reg;
    logic                  cmd_reg;
    logic                  hit_reg;
    logic [CNT_W-1:0]      fill_reg;
    token_t                launch_reg;
    logic                  m_tvalid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [COUNT_W-1:0]    count_reg;

    token_t                tok [CAPACITY+1];
    logic [CAPACITY-1:0]   tok_valid;
    logic [CAPACITY-1:0]   wr_sel;

    logic                  accept;
    logic                  slot_free;
    logic                  finish;
    logic                  insert_go;
    logic                  full;
    logic [CNT_W-1:0]      fill_next;
    logic [STATUS_W-1:0]   status_next;
    logic [CNT_W+COUNT_W-1:0] fill_ext;
    logic [TIME_WIDTH-1:0] in_start;
    logic [TIME_WIDTH-1:0] in_length;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign finish    = (state_reg == S_DONE) && slot_free;
    assign full      = (fill_reg == CNT_W'(CAPACITY));
    assign insert_go = finish && (cmd_reg == CMD_INSERT) && !hit_reg && !full;
    assign in_start  = s_tdata[TIME_WIDTH-1:0];
    assign in_length = s_tdata[FIELD_W +: TIME_WIDTH];

    always_comb
    begin
        fill_next   = fill_reg;
        status_next = ST_ADDED;
        priority if (cmd_reg == CMD_CLEAR)
        begin
            fill_next   = '0;
            status_next = ST_CLEARED;
        end
        else if (hit_reg)
        begin
            status_next = ST_OVERLAP;
        end
        else if (full)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            fill_next   = fill_reg + CNT_W'(1);
            status_next = ST_ADDED;
        end
        fill_ext = {{COUNT_W{1'b0}}, fill_next};
    end

    assign tok[0] = launch_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign wr_sel[gi]    = insert_go && (fill_reg == CNT_W'(gi));
            assign tok_valid[gi] = tok[gi+1].valid;
            kict_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .note    (note_reg),
                .wr_en   (wr_sel[gi]),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            note_reg     <= '0;
            cmd_reg      <= CMD_INSERT;
            hit_reg      <= 1'b0;
            fill_reg     <= '0;
            launch_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            status_reg   <= ST_ADDED;
            count_reg    <= '0;
        end
        else
        begin
            launch_reg.valid <= accept && (s_tuser[0] == CMD_INSERT);
            if (finish)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg            <= s_tuser[0];
                        hit_reg            <= 1'b0;
                        note_reg.start     <= in_start;
                        note_reg.stop      <= {1'b0, in_start} + {1'b0, in_length};
                        note_reg.key       <= s_tdata[2*FIELD_W +: KEY_W];
                        note_reg.velocity  <= s_tdata[2*FIELD_W+KEY_W +: VEL_W];
                        if (s_tuser[0] == CMD_CLEAR)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            launch_reg.remaining <= fill_reg;
                            launch_reg.hit       <= 1'b0;
                            state_reg            <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (tok[CAPACITY].valid)
                    begin
                        hit_reg   <= tok[CAPACITY].hit;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        fill_reg     <= fill_next;
                        status_reg   <= status_next;
                        count_reg    <= fill_ext[COUNT_W-1:0];
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, count_reg};
    assign m_tuser  = status_reg;

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({tok_valid, launch_reg.valid}))
        else $error("More than one scan token in the cell chain.");

    a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (tok_valid == '0))
        else $error("Scan token present while idle.");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("Fill count exceeds the table capacity.");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (status_reg == ST_CLEARED)) |-> (count_reg == '0))
        else $error("Clear result reports a nonzero entry count.");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_sel))
        else $error("More than one cell written in a cycle.");

endmodule

>>> test/keyed_interval_conflict_table_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for keyed_interval_conflict_table_unit: a directed table of note words, then random
// episodes of inserts and clears, results checked against a behavioral model or a typed row.
// Depends on kict_pkg and the RTL of the unit.
module keyed_interval_conflict_table_unit_tb;
    import kict_pkg::*;

    localparam int NUM_RANDOM   = 1800;
    localparam int NUM_DIRECTED = 24;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = CAPACITY + 8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } table_result_t;

    typedef struct packed {
        logic                cmd;
        logic [FIELD_W-1:0]  start;
        logic [FIELD_W-1:0]  span;
        logic [KEY_W-1:0]    key;
        logic [VEL_W-1:0]    velocity;
        logic                typed;
        table_result_t       want;
    } note_word_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [79:0]   s_tdata;
    logic [0:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [7:0]    m_tdata;
    logic [1:0]    m_tuser;

    logic          typed_now;
    table_result_t typed_want;

    logic [TIME_WIDTH-1:0] held_start [CAPACITY];
    logic [TIME_WIDTH-1:0] held_span [CAPACITY];
    logic [KEY_W-1:0]      held_key [CAPACITY];
    logic [VEL_W-1:0]      held_velocity [CAPACITY];
    int                    held_count;

    table_result_t result_q[$];
    int            fail_count;
    int            idle_cycles;
    bit            send_burst;
    bit            take_burst;

    // Rows with the typed flag set carry a result that is plain from the table contents.
    note_word_t dir_rows [NUM_DIRECTED] = '{
        '{CMD_INSERT, 32'd100, 32'd10, 7'd60, 7'd0, 1'b1, '{ST_ADDED, 7'd1}},
        '{CMD_INSERT, 32'd105, 32'd1, 7'd60, 7'd1, 1'b1, '{ST_OVERLAP, 7'd1}},
        '{CMD_INSERT, 32'd105, 32'd1, 7'd61, 7'd2, 1'b1, '{ST_ADDED, 7'd2}},
        '{CMD_INSERT, 32'd110, 32'd5, 7'd60, 7'd3, 1'b1, '{ST_ADDED, 7'd3}},
        '{CMD_INSERT, 32'd90, 32'd10, 7'd60, 7'd4, 1'b1, '{ST_ADDED, 7'd4}},
        '{CMD_INSERT, 32'd100, 32'd0, 7'd60, 7'd5, 1'b1, '{ST_ADDED, 7'd5}},
        '{CMD_INSERT, 32'd105, 32'd0, 7'd60, 7'd6, 1'b1, '{ST_OVERLAP, 7'd5}},
        '{CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127, 7'd127, 1'b1, '{ST_ADDED, 7'd6}},
        '{CMD_INSERT, 32'hFFFF_FFFF, 32'd1, 7'd127, 7'd127, 1'b1, '{ST_OVERLAP, 7'd6}},
        '{CMD_INSERT, 32'd0, 32'hFFFF_FFFF, 7'd127, 7'd0, 1'b1, '{ST_ADDED, 7'd7}},
        '{CMD_INSERT, 32'd0, 32'd0, 7'd0, 7'd0, 1'b1, '{ST_ADDED, 7'd8}},
        '{CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127, 7'd127, 1'b1, '{ST_CLEARED, 7'd0}},
        '{CMD_CLEAR, 32'd0, 32'd0, 7'd0, 7'd0, 1'b1, '{ST_CLEARED, 7'd0}},
        '{CMD_INSERT, 32'd100, 32'd10, 7'd60, 7'd5, 1'b1, '{ST_ADDED, 7'd1}},
        '{CMD_INSERT, 32'd0, 32'd0, 7'd60, 7'd33, 1'b0, '{ST_ADDED, 7'd0}},
        '{CMD_INSERT, 32'd200, 32'd0, 7'd60, 7'd127, 1'b0, '{ST_ADDED, 7'd0}},
        '{CMD_INSERT, 32'd150, 32'd100, 7'd60, 7'd64, 1'b0, '{ST_ADDED, 7'd0}},
        '{CMD_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 7'd42, 7'd85, 1'b0, '{ST_ADDED, 7'd0}},
        '{CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 7'd85, 7'd42, 1'b0, '{ST_ADDED, 7'd0}},
        '{CMD_CLEAR, 32'h1234_5678, 32'h9ABC_DEF0, 7'd85, 7'd42, 1'b1, '{ST_CLEARED, 7'd0}},
        '{CMD_INSERT, 32'h8000_0000, 32'h8000_0000, 7'd1, 7'd64, 1'b1, '{ST_ADDED, 7'd1}},
        '{CMD_INSERT, 32'hFFFF_FFFF, 32'd0, 7'd1, 7'd0, 1'b1, '{ST_OVERLAP, 7'd1}},
        '{CMD_INSERT, 32'd0, 32'h8000_0000, 7'd1, 7'd0, 1'b1, '{ST_ADDED, 7'd2}},
        '{CMD_INSERT, 32'h7FFF_FFFF, 32'd2, 7'd1, 7'd0, 1'b1, '{ST_OVERLAP, 7'd2}}
    };

    keyed_interval_conflict_table_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic table_result_t apply_note(input note_word_t w);
        table_result_t       r;
        logic [STOP_W-1:0]   note_stop;
        logic [STOP_W-1:0]   held_stop;
        bit                  hit;
        hit = 1'b0;
        if (w.cmd == CMD_CLEAR)
        begin
            held_count = 0;
            r.status = ST_CLEARED;
        end
        else
        begin
            note_stop = {1'b0, w.start[TIME_WIDTH-1:0]} + {1'b0, w.span[TIME_WIDTH-1:0]};
            for (int i = 0; i < held_count; i++)
            begin
                held_stop = {1'b0, held_start[i]} + {1'b0, held_span[i]};
                if (held_key[i] == w.key && {1'b0, held_start[i]} < note_stop &&
                    held_stop > {1'b0, w.start[TIME_WIDTH-1:0]})
                    hit = 1'b1;
            end
            if (hit)
                r.status = ST_OVERLAP;
            else if (held_count >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                held_start[held_count]    = w.start[TIME_WIDTH-1:0];
                held_span[held_count]     = w.span[TIME_WIDTH-1:0];
                held_key[held_count]      = w.key;
                held_velocity[held_count] = w.velocity;
                held_count++;
                r.status = ST_ADDED;
            end
        end
        r.count = COUNT_W'(held_count);
        return r;
    endfunction

    function automatic note_word_t clear_note();
        note_word_t w;
        w = '0;
        w.cmd      = CMD_CLEAR;
        w.start    = $urandom;
        w.span     = $urandom;
        w.key      = $urandom_range(0, 127);
        w.velocity = $urandom_range(0, 127);
        return w;
    endfunction

    // Dense episodes crowd a few keys into a short stretch of time to provoke overlaps;
    // sparse ones spread over the whole range and mostly fill the table.
    function automatic note_word_t random_note(input bit dense, input logic [KEY_W-1:0] key_base);
        note_word_t w;
        w = '0;
        w.cmd      = CMD_INSERT;
        w.velocity = $urandom_range(0, 127);
        if (dense)
        begin
            w.start = $urandom_range(0, 4095);
            w.span  = $urandom_range(0, 63);
            w.key   = key_base + KEY_W'($urandom_range(0, 7));
        end
        else
        begin
            case ($urandom_range(0, 7))
                0:       w.start = '0;
                1:       w.start = 32'hFFFF_FFFF - $urandom_range(0, 255);
                2:       w.start = $urandom_range(0, 255);
                default: w.start = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       w.span = '0;
                1:       w.span = 32'hFFFF_FFFF - $urandom_range(0, 255);
                2:       w.span = $urandom_range(1, 255);
                default: w.span = $urandom;
            endcase
            w.key = $urandom_range(0, 127);
        end
        return w;
    endfunction

    task automatic send_word(input note_word_t w);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= w.cmd;
        s_tdata    <= {2'b00, w.velocity, w.key, w.span, w.start};
        typed_now  <= w.typed;
        typed_want <= w.want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int               sent;
        int               episode_len;
        bit               dense;
        logic [KEY_W-1:0] key_base;
        note_word_t       w;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        typed_now  <= 1'b0;
        typed_want <= '0;
        held_count  = 0;
        fail_count  = 0;
        send_burst  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i]);
        drain_results();

        sent = 0;
        while (sent < NUM_RANDOM)
        begin
            dense       = $urandom_range(0, 1);
            key_base    = $urandom_range(0, 127);
            episode_len = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 130)
                                                       : $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0)
                drain_results();
            send_word(clear_note());
            sent++;
            for (int k = 0; k < episode_len && sent < NUM_RANDOM; k++)
            begin
                if ($urandom_range(0, 49) == 0)
                    w = clear_note();
                else
                    w = random_note(dense, key_base);
                send_word(w);
                sent++;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && result_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int stall;
        m_tready  <= 1'b0;
        take_burst = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = take_burst ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 39) == 0)
                take_burst = !take_burst;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : monitor
        note_word_t    seen;
        table_result_t predicted;
        table_result_t queued;
        table_result_t oldest;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                seen          = '0;
                seen.cmd      = s_tuser[0];
                seen.start    = s_tdata[31:0];
                seen.span     = s_tdata[63:32];
                seen.key      = s_tdata[70:64];
                seen.velocity = s_tdata[77:71];
                predicted     = apply_note(seen);
                queued        = typed_now ? typed_want : predicted;
                result_q      = {result_q, queued};
            end
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected result word: status %0d, entry_count %0d",
                           m_tuser, m_tdata[COUNT_W-1:0]);
                    fail_count++;
                end
                else
                begin
                    oldest = result_q.pop_front();
                    if (m_tuser != oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[COUNT_W-1:0] != oldest.count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               oldest.count, m_tdata[COUNT_W-1:0]);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
        else
            idle_cycles = 0;
    end

endmodule
